[rtl/pcpm_pkg.sv]
// pcpm_pkg: types, register codes, constants and helper functions of the
// particle code pattern match unit; no dependencies, used by every rtl file
package pcpm_pkg;

    // input item and result item
    typedef struct packed {
        logic signed [31:0] particle_code;
        logic [7:0]         daughter_count;
        logic               collect_requested;
    } item_t;

    typedef struct packed {
        logic matched;
        logic collect_item;
    } result_t;

    // decimal digits of the code magnitude, handed to the quark matcher
    typedef struct packed {
        logic       has_quarks;
        logic       negative;
        logic [3:0] digit3;
        logic [3:0] digit2;
        logic [3:0] digit1;
    } digit_set_t;

    // match modes
    typedef enum logic [1:0] {
        MODE_ANY     = 2'd0,
        MODE_EXACT   = 2'd1,
        MODE_QUARK   = 2'd2,
        MODE_QUANTUM = 2'd3
    } match_mode_t;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_MODE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_CODE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_FLAGS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_QUARK_A     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_QUARK_B     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_QUARK_C     = 3'd5;

    // match flag bit positions
    localparam int FLAG_CONJ   = 0;
    localparam int FLAG_OSC    = 1;
    localparam int FLAG_NOSC   = 2;
    localparam int FLAG_INV    = 3;
    localparam int FLAG_STABLE = 4;
    localparam int FLAG_LIFT   = 5;

    // codes that are their own charge conjugate
    localparam int NUM_SELF_CONJ = 23;
    localparam logic [31:0] SELF_CONJ [0:NUM_SELF_CONJ-1] = '{
        32'd12, 32'd22, 32'd23, 32'd25, 32'd35, 32'd36, 32'd111, 32'd113,
        32'd115, 32'd130, 32'd221, 32'd223, 32'd310, 32'd331, 32'd333,
        32'd441, 32'd443, 32'd445, 32'd10441, 32'd20113, 32'd20443,
        32'd100443, 32'd9000111
    };

    // 16^i mod 10000, weight of each nibble in the residue sum
    localparam logic [13:0] NIB_WEIGHT [0:7] = '{
        14'd1, 14'd16, 14'd256, 14'd4096, 14'd5536, 14'd8576, 14'd7216, 14'd5456
    };

    // reciprocal of 10000, exact quotient for any 19-bit residue sum
    localparam logic [19:0] RECIP_10000 = 20'd858994;
    localparam int          RECIP_SHIFT = 33;

    // magnitude limits for quark decoding
    localparam logic [31:0] MIN_QUARK_MAG = 32'd110;
    localparam logic [31:0] ION_LOW       = 32'd1000000000;
    localparam logic [31:0] ION_HIGH      = 32'd2000000000;

    function automatic logic is_self_conj(input logic [31:0] code);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_SELF_CONJ; i++) begin
            if (code == SELF_CONJ[i])
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // quotient of a value below 10000 by 1000
    function automatic logic [3:0] div1000(input logic [13:0] v);
        logic [3:0] q;
        q = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (v >= 14'(k * 1000))
            begin
                q = 4'(k);
            end
        end
        return q;
    endfunction

    // quotient of a value below 1000 by 100
    function automatic logic [3:0] div100(input logic [9:0] v);
        logic [3:0] q;
        q = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if ({1'b0, v} >= 11'(k * 100))
            begin
                q = 4'(k);
            end
        end
        return q;
    endfunction

    // quotient of a value below 100 by 10
    function automatic logic [3:0] div10(input logic [6:0] v);
        logic [3:0] q;
        q = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (v >= 7'(k * 10))
            begin
                q = 4'(k);
            end
        end
        return q;
    endfunction

    // quark digit: 7 to 9 mean no quark
    function automatic logic [2:0] quark_digit(input logic [3:0] d);
        return (d > 4'd6) ? 3'd0 : d[2:0];
    endfunction

    // signed quark to pattern code: 0 none, 1-6 quark, 7-12 antiquark
    function automatic logic [3:0] quark_code(input logic [2:0] mag, input logic anti,
                                              input logic conj);
        logic [3:0] code;
        if (mag == 3'd0)
        begin
            code = 4'd0;
        end
        else if (anti == conj)
        begin
            code = {1'b0, mag};
        end
        else
        begin
            code = {1'b0, mag} + 4'd6;
        end
        return code;
    endfunction

    function automatic logic slot(input logic [3:0] p, input logic [3:0] q);
        return (p == 4'd0) || (p == q);
    endfunction

    // pattern against quarks under all six orderings
    function automatic logic perm_match(input logic [3:0] a, input logic [3:0] b,
                                        input logic [3:0] c, input logic [3:0] x,
                                        input logic [3:0] y, input logic [3:0] z);
        return (slot(a, x) && slot(b, y) && slot(c, z)) ||
               (slot(a, x) && slot(b, z) && slot(c, y)) ||
               (slot(a, y) && slot(b, x) && slot(c, z)) ||
               (slot(a, y) && slot(b, z) && slot(c, x)) ||
               (slot(a, z) && slot(b, x) && slot(c, y)) ||
               (slot(a, z) && slot(b, y) && slot(c, x));
    endfunction

endpackage

[rtl/pcpm_quark_match.sv]
// pcpm_quark_match: decodes three decimal digits into signed quarks and
// matches them against the wildcard pattern; depends on pcpm_pkg
module pcpm_quark_match (
    input  pcpm_pkg::digit_set_t digits,
    input  logic [3:0]           pattern_a,
    input  logic [3:0]           pattern_b,
    input  logic [3:0]           pattern_c,
    input  logic                 conj_en,
    output logic                 hit
);
    import pcpm_pkg::*;

    logic [2:0] d3, d2, d1;
    logic [2:0] q1_mag, q2_mag, q3_mag;
    logic       q1_anti, q2_anti, q3_anti;
    logic [3:0] x_code, y_code, z_code;
    logic [3:0] xc_code, yc_code, zc_code;

    // digit to quark decode
    always_comb
    begin
        d3 = quark_digit(digits.digit3);
        d2 = quark_digit(digits.digit2);
        d1 = quark_digit(digits.digit1);
        q1_mag  = 3'd0;
        q2_mag  = 3'd0;
        q3_mag  = 3'd0;
        q1_anti = 1'b0;
        q2_anti = 1'b0;
        q3_anti = 1'b0;
        if (digits.has_quarks)
        begin
            if (d3 == 3'd0)
            begin
                // meson: odd digits are down type, sign follows charge
                q1_mag  = d2;
                q1_anti = d2[0];
                q2_mag  = d1;
                if ((d2 != 3'd0) && (d1[0] == d2[0]))
                begin
                    q2_anti = ~d1[0];
                end
                else
                begin
                    q2_anti = d1[0];
                end
            end
            else
            begin
                q1_mag = d3;
                q2_mag = d2;
                q3_mag = d1;
            end
            q1_anti = q1_anti ^ digits.negative;
            q2_anti = q2_anti ^ digits.negative;
            q3_anti = q3_anti ^ digits.negative;
        end
    end

    // pattern codes, plain and conjugated
    always_comb
    begin
        x_code  = quark_code(q1_mag, q1_anti, 1'b0);
        y_code  = quark_code(q2_mag, q2_anti, 1'b0);
        z_code  = quark_code(q3_mag, q3_anti, 1'b0);
        xc_code = quark_code(q1_mag, q1_anti, 1'b1);
        yc_code = quark_code(q2_mag, q2_anti, 1'b1);
        zc_code = quark_code(q3_mag, q3_anti, 1'b1);
        hit = perm_match(pattern_a, pattern_b, pattern_c, x_code, y_code, z_code) ||
              (conj_en &&
               perm_match(pattern_a, pattern_b, pattern_c, xc_code, yc_code, zc_code));
    end

endmodule

[rtl/particle_code_pattern_match_unit.sv]
// particle_code_pattern_match_unit: top level of the pattern matcher
// depends on pcpm_pkg and pcpm_quark_match
//
// usage
// - configuration: write cfg_data to register cfg_index while cfg_we is high;
//   0 mode, 1 target code, 2 flags, 3..5 pattern quarks; other indexes ignored
// - input: an item transfers at a clock edge with start high and busy low;
//   busy is always low, so one item can transfer in every cycle
// - output: done strobes for one cycle with the result; the result of an item
//   passes through the stage 1, stage 2 and output registers before it shows
// - throughput: one item per cycle, set by a three-register pipeline
//   (residue sum of the code magnitude, thousands digit, final match)
// - reset: all configuration registers clear to zero (match anything) and the
//   pipeline empties; no clearing pass is needed
// - the receiver cannot stall, each result is presented exactly once
module particle_code_pattern_match_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  pcpm_pkg::item_t                       item,
    output logic                                  done,
    output pcpm_pkg::result_t                     result,
    input  logic                                  cfg_we,
    input  logic [pcpm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [pcpm_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import pcpm_pkg::*;

    // configuration registers
    match_mode_t        mode_reg;
    logic signed [31:0] target_reg;
    logic [5:0]         flags_reg;
    logic [3:0]         quark_a_reg, quark_b_reg, quark_c_reg;

    // stage 1 registers
    logic        v1_reg;
    logic [18:0] sum_reg;
    logic [18:0] sum_next;
    logic        neg1_reg, has_q1_reg, exact1_reg, zero_dau1_reg, want1_reg;
    logic        has_q_next, exact_next;

    // stage 2 registers
    logic        v2_reg;
    logic [3:0]  d3_reg;
    logic [3:0]  d3_next;
    logic [9:0]  r3_reg;
    logic [9:0]  r3_next;
    logic        neg2_reg, has_q2_reg, exact2_reg, zero_dau2_reg, want2_reg;

    // output registers
    logic        done_reg;
    result_t     result_reg;
    result_t     result_next;

    logic [31:0] code_u, mag, conj_target;
    logic [38:0] quot_prod;
    logic [5:0]  quot;
    logic [18:0] rem_full;
    logic [13:0] rem10000;
    logic [3:0]  d2, d1;
    logic [6:0]  r2;
    logic        accept, quark_hit, res;
    digit_set_t  digits;

    assign accept = start && !busy;
    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_ANY;
            target_reg  <= '0;
            flags_reg   <= '0;
            quark_a_reg <= '0;
            quark_b_reg <= '0;
            quark_c_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MATCH_MODE:  mode_reg    <= match_mode_t'(cfg_data[1:0]);
                REG_TARGET_CODE: target_reg  <= signed'(cfg_data[31:0]);
                REG_MATCH_FLAGS: flags_reg   <= cfg_data[5:0];
                REG_QUARK_A:     quark_a_reg <= cfg_data[3:0];
                REG_QUARK_B:     quark_b_reg <= cfg_data[3:0];
                REG_QUARK_C:     quark_c_reg <= cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    // stage 1: magnitude, ion test, exact compare, residue sum mod 10000
    always_comb
    begin
        code_u = unsigned'(item.particle_code);
        mag    = code_u[31] ? (~code_u + 32'd1) : code_u;
        has_q_next = (mag >= MIN_QUARK_MAG) && !((mag >= ION_LOW) && (mag < ION_HIGH));
        conj_target = is_self_conj(unsigned'(target_reg)) ? unsigned'(target_reg)
                                                          : (~unsigned'(target_reg) + 32'd1);
        exact_next = (code_u == unsigned'(target_reg)) ||
                     (flags_reg[FLAG_CONJ] && (code_u == conj_target));
        sum_next = '0;
        for (int i = 0; i < 8; i++)
        begin
            sum_next = sum_next + ({15'd0, mag[4*i +: 4]} * {5'd0, NIB_WEIGHT[i]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg       <= sum_next;
        neg1_reg      <= code_u[31];
        has_q1_reg    <= has_q_next;
        exact1_reg    <= exact_next;
        zero_dau1_reg <= (item.daughter_count == 8'd0);
        want1_reg     <= item.collect_requested;
    end

    // stage 2: reduce residue mod 10000 by reciprocal, thousands digit
    always_comb
    begin
        quot_prod = {20'd0, sum_reg} * {19'd0, RECIP_10000};
        quot      = quot_prod[RECIP_SHIFT +: 6];
        rem_full  = sum_reg - ({13'd0, quot} * 19'd10000);
        rem10000  = rem_full[13:0];
        d3_next   = div1000(rem10000);
        r3_next   = 10'(rem10000 - ({10'd0, d3_next} * 14'd1000));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d3_reg        <= d3_next;
        r3_reg        <= r3_next;
        neg2_reg      <= neg1_reg;
        has_q2_reg    <= has_q1_reg;
        exact2_reg    <= exact1_reg;
        zero_dau2_reg <= zero_dau1_reg;
        want2_reg     <= want1_reg;
    end

    // stage 3: hundreds and tens digits, quark match
    always_comb
    begin
        d2 = div100(r3_reg);
        r2 = 7'(r3_reg - ({6'd0, d2} * 10'd100));
        d1 = div10(r2);
        digits.has_quarks = has_q2_reg;
        digits.negative   = neg2_reg;
        digits.digit3     = d3_reg;
        digits.digit2     = d2;
        digits.digit1     = d1;
    end

    pcpm_quark_match u_quark_match (
        .digits    (digits),
        .pattern_a (quark_a_reg),
        .pattern_b (quark_b_reg),
        .pattern_c (quark_c_reg),
        .conj_en   (flags_reg[FLAG_CONJ]),
        .hit       (quark_hit)
    );

    // mode select and flag handling
    always_comb
    begin
        res = 1'b0;
        case (mode_reg)
            MODE_ANY:
            begin
                res = 1'b1;
            end
            MODE_EXACT:
            begin
                res = exact2_reg;
                if (flags_reg[FLAG_OSC] || flags_reg[FLAG_NOSC])
                begin
                    res = 1'b0;
                end
                if (flags_reg[FLAG_INV])
                begin
                    res = !res;
                end
                if (flags_reg[FLAG_STABLE])
                begin
                    res = res && zero_dau2_reg;
                end
            end
            MODE_QUARK:
            begin
                res = quark_hit;
            end
            default:
            begin
                res = 1'b0;
            end
        endcase
        result_next.matched      = res;
        result_next.collect_item = res && flags_reg[FLAG_LIFT] && want2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // a result strobe follows every item in the last stage, and only then
    a_done_follows_stage2: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(v2_reg))
        else $error("result strobe does not follow the last pipeline stage");

    // a collected item is always a matched one
    a_collect_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.collect_item) |-> result.matched)
        else $error("collect flag without a match");

    // match-anything mode always matches
    a_any_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(mode_reg == MODE_ANY)) |-> result.matched)
        else $error("match-anything mode missed");

    // quantum mode never matches
    a_quantum_misses: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(mode_reg == MODE_QUANTUM)) |-> !result.matched)
        else $error("quantum mode matched");

endmodule

[dv/tb.sv]
// tb: self-checking testbench of particle_code_pattern_match_unit
// depends on pcpm_pkg for the item, result and mode types and the register and flag codes
`timescale 1ns / 100ps

module tb;
    import pcpm_pkg::*;

    localparam int          CLK_HALF       = 2;
    localparam int          RANDOM_ITEMS   = 750;
    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          END_WAIT       = 8;
    localparam int          PRINT_LIMIT    = 100;
    localparam logic [2:0]  REG_UNUSED_LO  = 3'd6;
    localparam logic [2:0]  REG_UNUSED_HI  = 3'd7;

    localparam logic [5:0]  F_CONJ   = 6'd1 << FLAG_CONJ;
    localparam logic [5:0]  F_OSC    = 6'd1 << FLAG_OSC;
    localparam logic [5:0]  F_NOSC   = 6'd1 << FLAG_NOSC;
    localparam logic [5:0]  F_INV    = 6'd1 << FLAG_INV;
    localparam logic [5:0]  F_STABLE = 6'd1 << FLAG_STABLE;
    localparam logic [5:0]  F_LIFT   = 6'd1 << FLAG_LIFT;

    localparam logic [31:0] CODE_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] CODE_MIN     = 32'h8000_0001;
    localparam logic [31:0] CODE_MOST_NEG = 32'h8000_0000;

    // some self-conjugate codes used as exact targets
    localparam int unsigned SELF_CONJ_PICKS [8] = '{
        111, 310, 22, 443, 9000111, 100443, 12, 130
    };

    // one predicted result and the item it belongs to
    typedef struct {
        item_t   it;
        result_t res;
    } predicted_t;

    // mirror of the configuration, predictor and queue of predicted results
    class match_scoreboard;
        match_mode_t  mode;
        logic [31:0]  target;
        logic [5:0]   flags;
        logic [3:0]   pat_a;
        logic [3:0]   pat_b;
        logic [3:0]   pat_c;
        predicted_t   predicted_results [$];
        int unsigned  errors;

        function new();
            mode   = MODE_ANY;
            target = '0;
            flags  = '0;
            pat_a  = '0;
            pat_b  = '0;
            pat_c  = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MATCH_MODE:  mode   = match_mode_t'(data[1:0]);
                REG_TARGET_CODE: target = data;
                REG_MATCH_FLAGS: flags  = data[5:0];
                REG_QUARK_A:     pat_a  = data[3:0];
                REG_QUARK_B:     pat_b  = data[3:0];
                REG_QUARK_C:     pat_c  = data[3:0];
                default: ;
            endcase
        endfunction

        function bit is_self_conjugate(logic [31:0] code);
            case (code)
                32'd12, 32'd22, 32'd23, 32'd25, 32'd35, 32'd36, 32'd111, 32'd113,
                32'd115, 32'd130, 32'd221, 32'd223, 32'd310, 32'd331, 32'd333,
                32'd441, 32'd443, 32'd445, 32'd10441, 32'd20113, 32'd20443,
                32'd100443, 32'd9000111: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        // negation modulo 2^32 unless the code is its own antiparticle
        function logic [31:0] conjugate(logic [31:0] code);
            if (is_self_conjugate(code))
                return code;
            return ~code + 32'd1;
        endfunction

        function int digit_of(longint unsigned m, int pos);
            longint unsigned base;
            base = 1;
            repeat (pos) base = base * 10;
            return int'((m / base) % 10);
        endfunction

        // down-type quarks carry -1, up-type +1
        function int charge_of(int d);
            if (d == 0)
                return 0;
            return (d % 2 == 1) ? -1 : 1;
        endfunction

        function logic [3:0] pattern_code_of(int q, bit conj);
            int a;
            a = (q < 0) ? -q : q;
            if (q == 0)
                return 4'd0;
            return ((q > 0) != conj) ? 4'(a) : 4'(a + 6);
        endfunction

        function bit slot_ok(logic [3:0] p, logic [3:0] q);
            return (p == 4'd0) || (p == q);
        endfunction

        // pattern slots against the three quarks in every distinct ordering
        function bit orderings_hit(int q [3], bit conj);
            logic [3:0] c [3];
            for (int i = 0; i < 3; i++)
                c[i] = pattern_code_of(q[i], conj);
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    for (int k = 0; k < 3; k++)
                        if (i != j && j != k && i != k &&
                            slot_ok(pat_a, c[i]) && slot_ok(pat_b, c[j]) &&
                            slot_ok(pat_c, c[k]))
                            return 1'b1;
            return 1'b0;
        endfunction

        function bit quark_content_hit(logic [31:0] code);
            bit              neg;
            longint unsigned mag;
            int              dig [1:3];
            int              q [3];
            bit              hit;
            neg = code[31];
            mag = {32'd0, neg ? (~code + 32'd1) : code};
            q = '{0, 0, 0};
            // ions and light codes carry no quarks
            if (mag >= 110 && digit_of(mag, 9) != 1)
            begin
                for (int p = 1; p <= 3; p++)
                begin
                    dig[p] = digit_of(mag, p);
                    if (dig[p] > 6)
                        dig[p] = 0;
                end
                if (dig[3] == 0)
                begin
                    // meson: quark and antiquark
                    q[0] = dig[2] * charge_of(dig[2]);
                    if (charge_of(dig[1]) == charge_of(dig[2]))
                        q[1] = -dig[1] * charge_of(dig[1]);
                    else
                        q[1] = dig[1] * charge_of(dig[1]);
                    q[2] = 0;
                end
                else
                begin
                    q[0] = dig[3];
                    q[1] = dig[2];
                    q[2] = dig[1];
                end
                if (neg)
                    for (int i = 0; i < 3; i++)
                        q[i] = -q[i];
            end
            hit = orderings_hit(q, 1'b0);
            if (flags[FLAG_CONJ])
                hit = hit || orderings_hit(q, 1'b1);
            return hit;
        endfunction

        function result_t predict_match(item_t it);
            result_t r;
            bit      hit;
            case (mode)
                MODE_ANY:   hit = 1'b1;
                MODE_EXACT:
                begin
                    hit = (it.particle_code == target);
                    if (flags[FLAG_CONJ])
                        hit = hit || (it.particle_code == conjugate(target));
                    if (flags[FLAG_OSC] || flags[FLAG_NOSC])
                        hit = 1'b0;
                    if (flags[FLAG_INV])
                        hit = !hit;
                    if (flags[FLAG_STABLE])
                        hit = hit && (it.daughter_count == 8'd0);
                end
                MODE_QUARK: hit = quark_content_hit(it.particle_code);
                default:    hit = 1'b0;
            endcase
            r.matched      = hit;
            r.collect_item = hit && flags[FLAG_LIFT] && it.collect_requested;
            return r;
        endfunction

        function void note_item(item_t it);
            predicted_t p;
            p.it  = it;
            p.res = predict_match(it);
            predicted_results = {predicted_results, p};
        endfunction

        function int pending();
            return predicted_results.size();
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task check_result(result_t got);
            predicted_t p;
            if (predicted_results.size() == 0)
            begin
                report_mismatch("result with no item outstanding");
            end
            else
            begin
                p = predicted_results.pop_front();
                if (got.matched !== p.res.matched)
                    report_mismatch($sformatf("code %0d ndau %0d: matched %b, predicted %b",
                        p.it.particle_code, p.it.daughter_count, got.matched,
                        p.res.matched));
                if (got.collect_item !== p.res.collect_item)
                    report_mismatch($sformatf("code %0d collect %b: collect_item %b, predicted %b",
                        p.it.particle_code, p.it.collect_requested, got.collect_item,
                        p.res.collect_item));
            end
        endtask
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    item_t                   item;
    logic                    done;
    result_t                 result;
    logic                    cfg_we;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    match_scoreboard         sb;
    logic [31:0]             cur_target;
    int unsigned             cycles;
    int                      sent;

    particle_code_pattern_match_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // result monitor, every strobed result is one transfer
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function item_t mk(logic [31:0] code, int ndau, bit want);
        item_t it;
        it.particle_code     = code;
        it.daughter_count    = 8'(ndau);
        it.collect_requested = want;
        return it;
    endfunction

    // quark digit, mostly real quarks and sometimes 7 to 9
    function int pick_digit();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(7, 9);
    endfunction

    // code shaped like the numbering scheme, with prefixes, ions and light codes
    function logic [31:0] hadron_code();
        int unsigned m;
        m = $urandom_range(0, 9);
        m += 10 * pick_digit();
        m += 100 * pick_digit();
        if ($urandom_range(0, 2) != 0)
            m += 1000 * pick_digit();
        case ($urandom_range(0, 11))
            0: m += 10000 * $urandom_range(1, 9);
            1: m += 100000 * $urandom_range(1, 9);
            2: m += 1000000000 + 10000 * $urandom_range(0, 99999);
            3: m = $urandom_range(0, 120);
            4: m += 2000000000;
            5: m += 9000000;
            default: ;
        endcase
        return $urandom_range(0, 1) ? (32'd0 - m) : m;
    endfunction

    function item_t random_item();
        logic [31:0] code;
        int          r;
        int          ndau;
        r = $urandom_range(0, 9);
        if (r < 3)
            code = cur_target;
        else if (r < 5)
            code = 32'd0 - cur_target;
        else if (r < 8)
            code = hadron_code();
        else
            code = $urandom;
        case ($urandom_range(0, 3))
            0: ndau = 0;
            1: ndau = 255;
            default: ndau = $urandom_range(0, 255);
        endcase
        return mk(code, ndau, 1'($urandom_range(0, 1)));
    endfunction

    function logic [3:0] random_pattern();
        int r;
        r = $urandom_range(0, 19);
        if (r < 7)
            return 4'd0;
        if (r < 18)
            return 4'($urandom_range(1, 12));
        return 4'($urandom_range(13, 15));
    endfunction

    // mostly short gaps, a few long
    function int random_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        if (r < 19)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // one input transfer
    task send(item_t it);
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
        sb.note_item(it);
    endtask

    task idle(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // hold the sender until every outstanding result has come back
    task drain();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // full register set written with the block idle, plus an unused index
    task set_config(match_mode_t m, logic [31:0] tgt, logic [5:0] fl,
                    logic [3:0] a, logic [3:0] b, logic [3:0] c);
        drain();
        cfg_write(REG_MATCH_MODE, 32'(m));
        cfg_write(REG_TARGET_CODE, tgt);
        cfg_write(REG_MATCH_FLAGS, 32'(fl));
        cfg_write(REG_QUARK_A, 32'(a));
        cfg_write(REG_QUARK_B, 32'(b));
        cfg_write(REG_QUARK_C, 32'(c));
        cfg_write($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI, $urandom);
        cfg_we <= 1'b0;
        cur_target = tgt;
    endtask

    task random_config(int phase);
        match_mode_t m;
        logic [31:0] tgt;
        logic [5:0]  fl;
        int          r;
        r = $urandom_range(0, 9);
        if (r == 0)
            m = MODE_ANY;
        else if (r < 5)
            m = MODE_EXACT;
        else if (r < 9)
            m = MODE_QUARK;
        else
            m = MODE_QUANTUM;
        case ($urandom_range(0, 9))
            0: tgt = CODE_MAX;
            1: tgt = CODE_MIN;
            2: tgt = 32'd0;
            3, 4:
            begin
                tgt = SELF_CONJ_PICKS[$urandom_range(0, 7)];
                if ($urandom_range(0, 1))
                    tgt = 32'd0 - tgt;
            end
            5, 6, 7: tgt = hadron_code();
            default: tgt = $urandom;
        endcase
        fl = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 9) < 6)
            fl = fl & ~(F_OSC | F_NOSC);
        // the first phases sit on the register extremes
        case (phase)
            0: set_config(MODE_EXACT, CODE_MAX, 6'h3F, 4'hF, 4'hF, 4'hF);
            1: set_config(MODE_QUARK, CODE_MIN, F_CONJ | F_LIFT, 4'd12, 4'd0, 4'd6);
            2: set_config(MODE_EXACT, CODE_MIN, F_CONJ | F_LIFT | F_STABLE, 4'd0, 4'd0, 4'd0);
            default: set_config(m, tgt, fl, random_pattern(), random_pattern(), random_pattern());
        endcase
    endtask

    task directed_items();
        // reset configuration matches anything and never collects
        send(mk(CODE_MAX, 255, 1));
        send(mk(CODE_MOST_NEG, 0, 1));
        send(mk(32'd0, 0, 0));
        // exact code with conjugate
        set_config(MODE_EXACT, 32'd211, F_CONJ, 4'd0, 4'd0, 4'd0);
        send(mk(32'd211, 2, 1));
        send(mk(-211, 2, 1));
        send(mk(32'd212, 0, 0));
        // self-conjugate target maps to itself
        set_config(MODE_EXACT, 32'd111, F_CONJ | F_LIFT, 4'd0, 4'd0, 4'd0);
        send(mk(32'd111, 0, 1));
        send(mk(-111, 0, 1));
        // conjugate of the most negative legal target
        set_config(MODE_EXACT, CODE_MIN, F_CONJ | F_LIFT, 4'd0, 4'd0, 4'd0);
        send(mk(CODE_MAX, 3, 1));
        // inverse then stable
        set_config(MODE_EXACT, 32'd22, F_INV | F_STABLE, 4'd0, 4'd0, 4'd0);
        send(mk(32'd22, 0, 0));
        send(mk(32'd23, 0, 1));
        send(mk(32'd23, 5, 0));
        // oscillation flags force a miss before inverse
        set_config(MODE_EXACT, 32'd22, F_OSC | F_INV | F_LIFT, 4'd0, 4'd0, 4'd0);
        send(mk(32'd22, 1, 1));
        set_config(MODE_EXACT, 32'd22, F_NOSC, 4'd0, 4'd0, 4'd0);
        send(mk(32'd22, 0, 0));
        // baryon under permutation and conjugation, ion and light codes
        set_config(MODE_QUARK, 32'd0, F_CONJ | F_LIFT, 4'd1, 4'd2, 4'd2);
        send(mk(32'd2212, 0, 1));
        send(mk(-2212, 7, 1));
        send(mk(32'd1000002212, 0, 0));
        send(mk(32'd50, 0, 1));
        // pattern code beyond the antiquarks never matches
        set_config(MODE_QUARK, 32'd0, F_LIFT, 4'd13, 4'd0, 4'd0);
        send(mk(32'd2212, 0, 1));
        // digits 7 to 9 are no quark, meson decoding
        set_config(MODE_QUARK, 32'd0, 6'd0, 4'd2, 4'd0, 4'd0);
        send(mk(32'd7982, 0, 0));
        send(mk(32'd321, 0, 0));
        // quantum mode
        set_config(MODE_QUANTUM, 32'd211, F_LIFT, 4'd0, 4'd0, 4'd0);
        send(mk(32'd211, 0, 1));
    endtask

    // stimulus and end of run
    initial
    begin
        int  phase;
        int  n;
        int  gap;
        bit  burst;
        sb         = new();
        cycles     = 0;
        sent       = 0;
        cur_target = '0;
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();

        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            random_config(phase);
            n     = $urandom_range(35, 65);
            burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < n; i++)
            begin
                send(random_item());
                sent++;
                gap = burst ? 0 : random_gap();
                if ($urandom_range(0, 39) == 0)
                    drain();
                else if (gap > 0)
                    idle(gap);
            end
            phase++;
        end

        drain();
        repeat (END_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
